FILE: hw/rtl/pue_pkg.sv
// shared types, codes and character helpers for the percent url byte encoder
`default_nettype none

package pue_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FORMAT_W   = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 2;
   localparam int unsigned MAX_RUN    = 5;
   localparam int unsigned RUN_LEN_W  = 3;

   // format codes
   localparam logic [FORMAT_W-1:0] FMT_PERCENT   = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_DOUBLE    = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_BACKSLASH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_ALL = 1'b1;

   // fixed characters
   localparam logic [BYTE_W-1:0] CH_PERCENT   = 8'h25;
   localparam logic [BYTE_W-1:0] CH_TWO       = 8'h32;
   localparam logic [BYTE_W-1:0] CH_FIVE      = 8'h35;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LOWER_X   = 8'h78;

   // one encoded run, characters in emission order from index 0
   typedef struct packed {
      logic [MAX_RUN-1:0][BYTE_W-1:0] chars;
      logic [RUN_LEN_W-1:0]           len;
      logic                           last;
   } run_type;

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         hex_char = 8'h30 + wide;
      end else begin
         hex_char = 8'h37 + wide;
      end
   endfunction

   function automatic logic is_unreserved(input logic [BYTE_W-1:0] b);
      is_unreserved = b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                8'h2D, 8'h5F, 8'h2E, 8'h7E};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/percent_url_byte_encoder.sv
// top level: configuration registers, byte encoder and character serialiser
// a byte's run enters the run register on transfer in, and its characters then pass the output register
// throughput: each byte runs to 1, 3, 4 or 5 characters, and the output register moves one character per
// cycle while the receiver is not stalling it; the next byte enters as the last character of the run goes out
// reset: synchronous, clears format, force flag and all valid state
`default_nettype none

module percent_url_byte_encoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration writes
   input  wire logic                           csr_we,
   input  wire logic [pue_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pue_pkg::CSR_DATA_W-1:0] csr_wdata,
   // input bytes
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [pue_pkg::BYTE_W-1:0]     req_in_byte,
   input  wire logic                           req_last_of_string,
   // encoded characters
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [pue_pkg::BYTE_W-1:0]          rsp_out_char,
   output logic                                rsp_run_last,
   output logic                                rsp_string_end
);

   // configuration registers; the user must write them only while idle, the block does not enforce it
   logic [pue_pkg::FORMAT_W-1:0] format_ff, format_in;
   logic                         force_all_ff, force_all_in;

   // encoded run for the byte on the input side
   pue_pkg::run_type             enc_run;

   always_comb begin
      format_in    = format_ff;
      force_all_in = force_all_ff;
      if (csr_we) begin
         case (csr_index)
            pue_pkg::CSR_FORMAT:    format_in    = csr_wdata;
            pue_pkg::CSR_FORCE_ALL: force_all_in = csr_wdata[0];
            default:                format_in    = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= pue_pkg::FMT_PERCENT;
         force_all_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         force_all_ff <= force_all_in;
      end
   end

   // expansion of the byte into its full character run, done on transfer in
   pue_encode u_encode (
      .in_byte        (req_in_byte),
      .last_of_string (req_last_of_string),
      .format         (format_ff),
      .force_all      (force_all_ff),
      .run            (enc_run)
   );

   // run register feeding the output register a character per cycle while the receiver is not stalling it
   pue_serial u_serial (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .enc_run        (enc_run),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/pue_encode.sv
// byte to character run expansion for the three output formats
`default_nettype none

module pue_encode (
   input  wire logic [pue_pkg::BYTE_W-1:0]   in_byte,
   input  wire logic                         last_of_string,
   input  wire logic [pue_pkg::FORMAT_W-1:0] format,
   input  wire logic                         force_all,
   output pue_pkg::run_type                  run
);

   logic [pue_pkg::BYTE_W-1:0] hi_char;
   logic [pue_pkg::BYTE_W-1:0] lo_char;

   assign hi_char = pue_pkg::hex_char(in_byte[7:4]);
   assign lo_char = pue_pkg::hex_char(in_byte[3:0]);

   always_comb begin
      run       = '0;
      run.last  = last_of_string;
      case (format)
         pue_pkg::FMT_PERCENT, pue_pkg::FMT_DOUBLE: begin
            if (pue_pkg::is_unreserved(in_byte) && !force_all) begin
               run.chars[0] = in_byte;
               run.len      = 3'd1;
            end else if (format == pue_pkg::FMT_DOUBLE) begin
               run.chars[0] = pue_pkg::CH_PERCENT;
               run.chars[1] = pue_pkg::CH_TWO;
               run.chars[2] = pue_pkg::CH_FIVE;
               run.chars[3] = hi_char;
               run.chars[4] = lo_char;
               run.len      = 3'd5;
            end else begin
               run.chars[0] = pue_pkg::CH_PERCENT;
               run.chars[1] = hi_char;
               run.chars[2] = lo_char;
               run.len      = 3'd3;
            end
         end
         default: begin
            // backslash hex, also the unused code
            run.chars[0] = pue_pkg::CH_BACKSLASH;
            run.chars[1] = pue_pkg::CH_LOWER_X;
            run.chars[2] = hi_char;
            run.chars[3] = lo_char;
            run.len      = 3'd4;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pue_serial.sv
// run register and output register, one character per transfer
`default_nettype none

module pue_serial (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire pue_pkg::run_type           enc_run,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [pue_pkg::BYTE_W-1:0]      rsp_out_char,
   output logic                            rsp_run_last,
   output logic                            rsp_string_end
);

   pue_pkg::run_type                   run_ff, run_in;
   logic                               run_valid_ff, run_valid_in;
   logic [pue_pkg::RUN_LEN_W-1:0]      idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pue_pkg::BYTE_W-1:0]         char_ff, char_in;
   logic                               run_last_ff, run_last_in;
   logic                               str_end_ff, str_end_in;

   logic                               out_load;
   logic                               at_end;
   logic                               take;

   always_comb begin
      out_load = run_valid_ff && (!rsp_valid_ff || rsp_ready);
      at_end   = (idx_ff == (run_ff.len - 3'd1));
      req_ready = !run_valid_ff || (out_load && at_end);
      take      = req_valid && req_ready;

      run_in       = take ? enc_run : run_ff;
      run_valid_in = take ? 1'b1 : ((out_load && at_end) ? 1'b0 : run_valid_ff);
      if (take) begin
         idx_in = '0;
      end else if (out_load) begin
         idx_in = idx_ff + 3'd1;
      end else begin
         idx_in = idx_ff;
      end

      case (idx_ff)
         3'd0:    char_in = run_ff.chars[0];
         3'd1:    char_in = run_ff.chars[1];
         3'd2:    char_in = run_ff.chars[2];
         3'd3:    char_in = run_ff.chars[3];
         3'd4:    char_in = run_ff.chars[4];
         default: char_in = run_ff.chars[0];
      endcase
      run_last_in = at_end;
      str_end_in  = at_end && run_ff.last;

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (out_load) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         str_end_ff  <= str_end_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = str_end_ff;

   // a held run always has characters left to send
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (run_ff.len != 3'd0) && (idx_ff < run_ff.len))
      else $error("run index outside run length");

   // a shown character that does not close its run leaves the run held
   a_run_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !run_last_ff |-> run_valid_ff)
      else $error("run dropped before its last character");

   // string end only on a run's last character
   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && str_end_ff |-> run_last_ff)
      else $error("string end without run end");

   // no new item taken while a run still has characters to send
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff && !(out_load && at_end) |-> !req_ready)
      else $error("input taken over an unfinished run");

endmodule

`default_nettype wire

FILE: tb/sv/url_escape_check.sv
`timescale 1ns / 100ps
// monitor that predicts the encoded character stream and compares every response transfer

module url_escape_check (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [pue_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pue_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [pue_pkg::BYTE_W-1:0]     req_in_byte,
   input  wire logic                           req_last_of_string,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [pue_pkg::BYTE_W-1:0]     rsp_out_char,
   input  wire logic                           rsp_run_last,
   input  wire logic                           rsp_string_end,
   output int                                  fail_count,
   output int                                  pending
);

   typedef struct packed {
      logic [pue_pkg::BYTE_W-1:0] ch;
      logic                       run_end;
      logic                       str_end;
   } enc_char_type;

   enc_char_type                   expected_chars[$];
   logic [pue_pkg::FORMAT_W-1:0]   cur_format;
   logic                           cur_force;
   int                             errors;
   enc_char_type                   got;
   enc_char_type                   want;

   function automatic logic [pue_pkg::BYTE_W-1:0] nibble_ascii(input logic [3:0] n);
      logic [pue_pkg::BYTE_W-1:0] v;
      v = {4'h0, n};
      return (n > 4'd9) ? (8'h41 + v - 8'h0A) : (8'h30 + v);
   endfunction

   function automatic logic plain_char(input logic [pue_pkg::BYTE_W-1:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
             b == 8'h2E || b == 8'h7E;
   endfunction

   // queue the characters that one byte should turn into
   task automatic expand_byte(input logic [pue_pkg::BYTE_W-1:0] b, input logic last);
      logic [pue_pkg::BYTE_W-1:0] seq[5];
      int                         n;
      enc_char_type               e;
      n = 0;
      if (cur_format == pue_pkg::FMT_PERCENT || cur_format == pue_pkg::FMT_DOUBLE) begin
         if (plain_char(b) && !cur_force) begin
            seq[n] = b;
            n++;
         end else begin
            seq[n] = pue_pkg::CH_PERCENT;
            n++;
            if (cur_format == pue_pkg::FMT_DOUBLE) begin
               seq[n] = pue_pkg::CH_TWO;
               n++;
               seq[n] = pue_pkg::CH_FIVE;
               n++;
            end
            seq[n] = nibble_ascii(b[7:4]);
            n++;
            seq[n] = nibble_ascii(b[3:0]);
            n++;
         end
      end else begin
         seq[0] = pue_pkg::CH_BACKSLASH;
         seq[1] = pue_pkg::CH_LOWER_X;
         seq[2] = nibble_ascii(b[7:4]);
         seq[3] = nibble_ascii(b[3:0]);
         n = 4;
      end
      for (int k = 0; k < n; k++) begin
         e.ch      = seq[k];
         e.run_end = (k == n - 1);
         e.str_end = (k == n - 1) && last;
         expected_chars.push_back(e);
      end
   endtask

   task automatic note_failure(input string what);
      errors++;
      if (errors <= 10) $display("%0t %s", $time, what);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      if (reset) begin
         cur_format = pue_pkg::FMT_PERCENT;
         cur_force  = 1'b0;
         expected_chars.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == pue_pkg::CSR_FORMAT) cur_format = csr_wdata;
            else if (csr_index == pue_pkg::CSR_FORCE_ALL) cur_force = csr_wdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_char, rsp_run_last, rsp_string_end};
            if (expected_chars.size() == 0) begin
               note_failure($sformatf("unexpected char %02h run_last %0b string_end %0b",
                                      got.ch, got.run_end, got.str_end));
            end else begin
               want = expected_chars.pop_front();
               if (got != want)
                  note_failure($sformatf(
                     "expected char %02h run_last %0b string_end %0b, got %02h %0b %0b",
                     want.ch, want.run_end, want.str_end, got.ch, got.run_end, got.str_end));
            end
         end
         if (req_valid && req_ready) expand_byte(req_in_byte, req_last_of_string);
      end
      fail_count <= errors;
      pending    <= expected_chars.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// top-level testbench: stimulus, flow control and verdict for the percent url byte encoder

module testbench;

   // the fourth format code is unused and should behave as backslash hex
   localparam logic [pue_pkg::FORMAT_W-1:0] FMT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 250;   // receiver hold-off, long enough to back up the input
   localparam int SETTLE      = 8;     // idle cycles once the expected queue is empty
   localparam int PHASE_ITEMS = 75;
   localparam int SEG_ITEMS   = 14;

   typedef logic [pue_pkg::BYTE_W-1:0] byte_seq_type[$];
   typedef logic [pue_pkg::FORMAT_W-1:0] fmt_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [pue_pkg::CSR_IDX_W-1:0]  csr_index = pue_pkg::CSR_FORMAT;
   logic [pue_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [pue_pkg::BYTE_W-1:0]     req_in_byte = '0;
   logic                           req_last_of_string = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [pue_pkg::BYTE_W-1:0]     rsp_out_char;
   logic                           rsp_run_last;
   logic                           rsp_string_end;
   int                             fail_count;
   int                             pending;

   // idle percentages of each side, changed per phase
   int send_idle_pct = 23;
   int recv_idle_pct = 60;
   // long hold-off requests from the stimulus, served by the receiver process
   int hold_asks = 0;
   int hold_served = 0;
   int bytes_sent = 0;

   always #1 clock = ~clock;

   percent_url_byte_encoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_last_of_string (req_last_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_end     (rsp_string_end)
   );

   url_escape_check u_check (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_last_of_string (req_last_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_end     (rsp_string_end),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   // receiver: random back-pressure, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("percent_url_byte_encoder verification failed");
      $finish;
   end

   // offer one byte, with random idle cycles ahead of it; returns at the edge
   // where the transfer happens, valid left high
   task automatic send_byte(input logic [pue_pkg::BYTE_W-1:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_in_byte        <= b;
      req_last_of_string <= last;
      // ready is looked at mid-cycle, where nothing is changing
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      bytes_sent++;
   endtask

   // mostly unreserved characters and marks, the rest any byte at all
   function automatic logic [pue_pkg::BYTE_W-1:0] pick_byte();
      int k;
      case ($urandom_range(0, 3))
         0: begin
            k = $urandom_range(0, 61);
            if (k < 26) return 8'h41 + k[7:0];
            else if (k < 52) return 8'h61 + k[7:0] - 8'd26;
            else return 8'h30 + k[7:0] - 8'd52;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: return 8'h2D;
               1: return 8'h5F;
               2: return 8'h2E;
               default: return 8'h7E;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_string(input int len);
      for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
   endtask

   task automatic send_fixed(input byte_seq_type s);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   // sender stops and waits for every expected character to come out
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // registers only change once the block has gone quiet
   task automatic set_mode(input logic [pue_pkg::FORMAT_W-1:0] fmt, input logic frc);
      drain();
      csr_we    <= 1'b1;
      csr_index <= pue_pkg::CSR_FORMAT;
      csr_wdata <= fmt;
      @(posedge clock);
      csr_index <= pue_pkg::CSR_FORCE_ALL;
      csr_wdata <= {1'b0, frc};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // random strings under a rotating set of modes
   task automatic run_phase(input int snd_pct, input int rcv_pct, input int phase_no,
                            input logic with_hold);
      int      target;
      int      seg;
      int      seg_end;
      fmt_type fmt;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      target = bytes_sent + PHASE_ITEMS;
      seg = 0;
      while (bytes_sent < target) begin
         fmt = fmt_type'((seg + phase_no) % 4);
         set_mode(fmt, 1'($urandom_range(0, 1)));
         // receiver stops for a long stretch while bytes keep coming
         if (with_hold && seg == 1) hold_asks++;
         seg_end = bytes_sent + SEG_ITEMS;
         while (bytes_sent < seg_end) send_string($urandom_range(1, 8));
         seg++;
      end
   endtask

   initial begin
      byte_seq_type msg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero byte, both ends of the byte range, every unreserved class
      msg = {8'h00, 8'h41, 8'h7A, 8'h39, 8'h7E, 8'h2D, 8'h5F, 8'h2E, 8'hFF};
      send_fixed(msg);
      set_mode(pue_pkg::FMT_DOUBLE, 1'b0);
      msg = {8'h61, 8'h2F, 8'h80};
      send_fixed(msg);
      // force flag in both percent formats
      set_mode(pue_pkg::FMT_PERCENT, 1'b1);
      msg = {8'h5A, 8'h30};
      send_fixed(msg);
      set_mode(pue_pkg::FMT_DOUBLE, 1'b1);
      msg = {8'h6D, 8'h7F};
      send_fixed(msg);
      // backslash hex, force flag has no effect there
      set_mode(pue_pkg::FMT_BACKSLASH, 1'b0);
      msg = {8'h71, 8'h00, 8'hFF};
      send_fixed(msg);
      set_mode(pue_pkg::FMT_BACKSLASH, 1'b1);
      msg = {8'h42, 8'h3A};
      send_fixed(msg);
      // unused format code
      set_mode(FMT_UNUSED, 1'b0);
      msg = {8'h6B, 8'hA5};
      send_fixed(msg);

      run_phase(23, 60, 0, 1'b1);
      run_phase(60, 23, 1, 1'b0);
      run_phase(0, 0, 2, 1'b1);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("percent_url_byte_encoder verification clean");
      end else begin
         $display("percent_url_byte_encoder verification failed");
      end
      $finish;
   end

endmodule
